[hdl/jtl_pkg.sv]
// Shared types and constants for the JSON token lexer.
`default_nettype none

package jtl_pkg;

    typedef enum logic [1:0] {
        MODE_IDLE    = 2'd0,
        MODE_STRING  = 2'd1,
        MODE_NUMBER  = 2'd2,
        MODE_LITERAL = 2'd3
    } lex_mode_t;

    localparam logic [3:0] K_LBRACE   = 4'd0;
    localparam logic [3:0] K_RBRACE   = 4'd1;
    localparam logic [3:0] K_LBRACKET = 4'd2;
    localparam logic [3:0] K_RBRACKET = 4'd3;
    localparam logic [3:0] K_COLON    = 4'd4;
    localparam logic [3:0] K_COMMA    = 4'd5;
    localparam logic [3:0] K_STRING   = 4'd6;
    localparam logic [3:0] K_NUMBER   = 4'd7;
    localparam logic [3:0] K_NULL     = 4'd8;
    localparam logic [3:0] K_BOOL     = 4'd9;

    localparam logic [7:0] CH_LBRACE   = 8'h7B;
    localparam logic [7:0] CH_RBRACE   = 8'h7D;
    localparam logic [7:0] CH_LBRACKET = 8'h5B;
    localparam logic [7:0] CH_RBRACKET = 8'h5D;
    localparam logic [7:0] CH_COLON    = 8'h3A;
    localparam logic [7:0] CH_COMMA    = 8'h2C;
    localparam logic [7:0] CH_QUOTE    = 8'h22;
    localparam logic [7:0] CH_MINUS    = 8'h2D;
    localparam logic [7:0] CH_DOT      = 8'h2E;
    localparam logic [7:0] CH_ZERO     = 8'h30;
    localparam logic [7:0] CH_NINE     = 8'h39;
    localparam logic [7:0] CH_N        = 8'h6E;
    localparam logic [7:0] CH_T        = 8'h74;
    localparam logic [7:0] CH_F        = 8'h66;
    localparam logic [7:0] CH_BSLASH   = 8'h5C;
    localparam logic [7:0] CH_NEWLINE  = 8'h0A;

    localparam logic [2:0] SKIP_SHORT = 3'd3;
    localparam logic [2:0] SKIP_LONG  = 3'd4;

    localparam int MAX_EVENTS  = 3;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    typedef struct packed {
        logic [3:0]  kind;
        logic        begins;
        logic        ends;
        logic        has_byte;
        logic [7:0]  value_byte;
        logic        bool_true;
        logic [15:0] line_number;
        logic [15:0] column_number;
        logic        error_flag;
    } token_event_t;

    typedef struct packed {
        token_event_t [MAX_EVENTS-1:0] ev;
        logic [1:0]                    count;
    } event_bundle_t;

    function automatic token_event_t make_event(
        input logic [3:0]  kind,
        input logic        b,
        input logic        e,
        input logic        has,
        input logic [7:0]  val,
        input logic        bt,
        input logic [15:0] ln,
        input logic [15:0] col,
        input logic        err
    );
        token_event_t t;
        t.kind          = kind;
        t.begins        = b;
        t.ends          = e;
        t.has_byte      = has;
        t.value_byte    = has ? val : 8'd0;
        t.bool_true     = bt;
        t.line_number   = ln;
        t.column_number = col;
        t.error_flag    = err;
        return t;
    endfunction

    function automatic event_bundle_t add_event(
        input event_bundle_t bun,
        input token_event_t  t
    );
        event_bundle_t r;
        r             = bun;
        r.ev[r.count] = t;
        r.count       = r.count + 2'd1;
        return r;
    endfunction

endpackage

`default_nettype wire

[hdl/jtl_front.sv]
// Front end: lexer state and classification of each text byte into a bundle of events.
`default_nettype none

module jtl_front #(
    parameter int POSITION_BITS = 16
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic [7:0]             text_byte,
    input  wire logic                   end_of_text,
    input  wire logic                   accept,
    output jtl_pkg::event_bundle_t      bundle
);
    import jtl_pkg::*;

    localparam logic [POSITION_BITS-1:0] POS_ONE = POSITION_BITS'(1);
    localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

    lex_mode_t                mode_reg, mode_next;
    logic [2:0]               skip_reg, skip_next;
    logic                     bs_reg, bs_next;
    logic [POSITION_BITS-1:0] line_reg, line_next;
    logic [POSITION_BITS-1:0] col_reg, col_next;
    logic [POSITION_BITS-1:0] tok_line_reg, tok_line_next;
    logic [POSITION_BITS-1:0] tok_col_reg, tok_col_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_IDLE;
            skip_reg     <= 3'd0;
            bs_reg       <= 1'b0;
            line_reg     <= POS_ONE;
            col_reg      <= '0;
            tok_line_reg <= POS_ONE;
            tok_col_reg  <= '0;
        end
        else if (accept)
        begin
            mode_reg     <= mode_next;
            skip_reg     <= skip_next;
            bs_reg       <= bs_next;
            line_reg     <= line_next;
            col_reg      <= col_next;
            tok_line_reg <= tok_line_next;
            tok_col_reg  <= tok_col_next;
        end
    end

    always_comb
    begin
        logic [POSITION_BITS-1:0] col_inc;
        logic [15:0]              tl16;
        logic [15:0]              tc16;
        logic [15:0]              il16;
        logic [15:0]              ic16;
        logic                     fresh;
        logic                     str_done;
        logic                     is_digit;

        mode_next     = mode_reg;
        skip_next     = skip_reg;
        bs_next       = bs_reg;
        tok_line_next = tok_line_reg;
        tok_col_next  = tok_col_reg;
        line_next     = line_reg;
        col_inc       = (col_reg == POS_MAX) ? col_reg : col_reg + POS_ONE;
        col_next      = col_inc;
        tl16          = 16'(tok_line_reg);
        tc16          = 16'(tok_col_reg);
        il16          = 16'(line_reg);
        ic16          = 16'(col_inc);
        fresh         = 1'b0;
        str_done      = 1'b0;
        is_digit      = (text_byte >= CH_ZERO) && (text_byte <= CH_NINE);
        bundle        = '0;

        case (mode_reg)
            MODE_STRING:
            begin
                if (bs_reg)
                begin
                    bs_next = 1'b0;
                    if (text_byte == CH_QUOTE)
                    begin
                        bundle   = add_event(bundle, make_event(K_STRING, 1'b0, 1'b0, 1'b1,
                                       CH_QUOTE, 1'b0, tl16, tc16, 1'b0));
                        str_done = 1'b1;
                    end
                    else
                    begin
                        bundle = add_event(bundle, make_event(K_STRING, 1'b0, 1'b0, 1'b1,
                                     CH_BSLASH, 1'b0, tl16, tc16, 1'b0));
                    end
                end
                if (!str_done)
                begin
                    if (text_byte == CH_BSLASH)
                    begin
                        bs_next = 1'b1;
                    end
                    else if (text_byte == CH_QUOTE)
                    begin
                        bundle    = add_event(bundle, make_event(K_STRING, 1'b0, 1'b1, 1'b0,
                                        8'd0, 1'b0, tl16, tc16, 1'b0));
                        mode_next = MODE_IDLE;
                    end
                    else
                    begin
                        bundle = add_event(bundle, make_event(K_STRING, 1'b0, 1'b0, 1'b1,
                                     text_byte, 1'b0, tl16, tc16, 1'b0));
                    end
                end
            end
            MODE_NUMBER:
            begin
                if (is_digit || text_byte == CH_DOT)
                begin
                    bundle = add_event(bundle, make_event(K_NUMBER, 1'b0, 1'b0, 1'b1,
                                 text_byte, 1'b0, tl16, tc16, 1'b0));
                end
                else
                begin
                    bundle    = add_event(bundle, make_event(K_NUMBER, 1'b0, 1'b1, 1'b0,
                                    8'd0, 1'b0, tl16, tc16, 1'b0));
                    mode_next = MODE_IDLE;
                    fresh     = 1'b1;
                end
            end
            MODE_LITERAL:
            begin
                skip_next = (skip_reg != 3'd0) ? skip_reg - 3'd1 : 3'd0;
                if (skip_next == 3'd0)
                begin
                    mode_next = MODE_IDLE;
                end
            end
            default:
            begin
                mode_next = MODE_IDLE;
                fresh     = 1'b1;
            end
        endcase

        // A byte taken while idle, or one that closes a number, starts something new.
        if (fresh)
        begin
            case (text_byte)
                CH_LBRACE:   bundle = add_event(bundle, make_event(K_LBRACE, 1'b1, 1'b1,
                                 1'b0, 8'd0, 1'b0, il16, ic16, 1'b0));
                CH_RBRACE:   bundle = add_event(bundle, make_event(K_RBRACE, 1'b1, 1'b1,
                                 1'b0, 8'd0, 1'b0, il16, ic16, 1'b0));
                CH_LBRACKET: bundle = add_event(bundle, make_event(K_LBRACKET, 1'b1, 1'b1,
                                 1'b0, 8'd0, 1'b0, il16, ic16, 1'b0));
                CH_RBRACKET: bundle = add_event(bundle, make_event(K_RBRACKET, 1'b1, 1'b1,
                                 1'b0, 8'd0, 1'b0, il16, ic16, 1'b0));
                CH_COLON:    bundle = add_event(bundle, make_event(K_COLON, 1'b1, 1'b1,
                                 1'b0, 8'd0, 1'b0, il16, ic16, 1'b0));
                CH_COMMA:    bundle = add_event(bundle, make_event(K_COMMA, 1'b1, 1'b1,
                                 1'b0, 8'd0, 1'b0, il16, ic16, 1'b0));
                CH_QUOTE:
                begin
                    tok_line_next = line_reg;
                    tok_col_next  = col_inc;
                    mode_next     = MODE_STRING;
                    bs_next       = 1'b0;
                    bundle        = add_event(bundle, make_event(K_STRING, 1'b1, 1'b0,
                                        1'b0, 8'd0, 1'b0, il16, ic16, 1'b0));
                end
                CH_N:
                begin
                    bundle    = add_event(bundle, make_event(K_NULL, 1'b1, 1'b1,
                                    1'b0, 8'd0, 1'b0, il16, ic16, 1'b0));
                    mode_next = MODE_LITERAL;
                    skip_next = SKIP_SHORT;
                end
                CH_T:
                begin
                    bundle    = add_event(bundle, make_event(K_BOOL, 1'b1, 1'b1,
                                    1'b0, 8'd0, 1'b1, il16, ic16, 1'b0));
                    mode_next = MODE_LITERAL;
                    skip_next = SKIP_SHORT;
                end
                CH_F:
                begin
                    bundle    = add_event(bundle, make_event(K_BOOL, 1'b1, 1'b1,
                                    1'b0, 8'd0, 1'b0, il16, ic16, 1'b0));
                    mode_next = MODE_LITERAL;
                    skip_next = SKIP_LONG;
                end
                default:
                begin
                    if (is_digit || text_byte == CH_MINUS)
                    begin
                        tok_line_next = line_reg;
                        tok_col_next  = col_inc;
                        mode_next     = MODE_NUMBER;
                        bundle        = add_event(bundle, make_event(K_NUMBER, 1'b1, 1'b0,
                                            1'b1, text_byte, 1'b0, il16, ic16, 1'b0));
                    end
                end
            endcase
        end

        if (text_byte == CH_NEWLINE)
        begin
            line_next = (line_reg == POS_MAX) ? line_reg : line_reg + POS_ONE;
            col_next  = '0;
        end

        // The final byte closes whatever token is still open and returns to the reset state.
        if (end_of_text)
        begin
            if (mode_next == MODE_STRING)
            begin
                if (bs_next)
                begin
                    bundle = add_event(bundle, make_event(K_STRING, 1'b0, 1'b0, 1'b1,
                                 CH_BSLASH, 1'b0, 16'(tok_line_next), 16'(tok_col_next),
                                 1'b0));
                end
                bundle = add_event(bundle, make_event(K_STRING, 1'b0, 1'b1, 1'b0, 8'd0,
                             1'b0, 16'(tok_line_next), 16'(tok_col_next), 1'b1));
            end
            else if (mode_next == MODE_NUMBER)
            begin
                bundle = add_event(bundle, make_event(K_NUMBER, 1'b0, 1'b1, 1'b0, 8'd0,
                             1'b0, 16'(tok_line_next), 16'(tok_col_next), 1'b0));
            end
            mode_next     = MODE_IDLE;
            skip_next     = 3'd0;
            bs_next       = 1'b0;
            line_next     = POS_ONE;
            col_next      = '0;
            tok_line_next = POS_ONE;
            tok_col_next  = '0;
        end
    end

endmodule

`default_nettype wire

[hdl/jtl_queue.sv]
// Small queue of event bundles between the front end and the back end.
`default_nettype none

module jtl_queue (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   push,
    input  wire jtl_pkg::event_bundle_t push_data,
    input  wire logic                   pop,
    output logic                        full,
    output logic                        head_valid,
    output jtl_pkg::event_bundle_t      head
);
    import jtl_pkg::*;

    event_bundle_t         entry_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_AW:0]     count_reg, count_next;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    assign full       = (count_reg == (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = entry_reg[rd_ptr_reg];

endmodule

`default_nettype wire

[hdl/jtl_back.sv]
// Back end: unpacks the head bundle into single events and holds the output register.
`default_nettype none

module jtl_back (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   head_valid,
    input  wire jtl_pkg::event_bundle_t head,
    output logic                        pop,
    input  wire logic                   out_stall,
    output logic                        out_valid,
    output jtl_pkg::token_event_t       out_event,
    output logic                        out_last
);
    import jtl_pkg::*;

    logic         valid_reg, valid_next;
    logic [1:0]   idx_reg, idx_next;
    token_event_t event_reg;
    logic         last_reg;
    logic         load;
    logic         at_last;

    assign load    = head_valid && (!valid_reg || !out_stall);
    assign at_last = ((idx_reg + 2'd1) == head.count);
    assign pop     = load && at_last;

    always_comb
    begin
        valid_next = valid_reg;
        idx_next   = idx_reg;
        if (load)
        begin
            valid_next = 1'b1;
            idx_next   = at_last ? 2'd0 : idx_reg + 2'd1;
        end
        else if (!out_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            event_reg <= head.ev[idx_reg];
            last_reg  <= at_last;
        end
    end

    assign out_valid = valid_reg;
    assign out_event = event_reg;
    assign out_last  = last_reg;

endmodule

`default_nettype wire

[hdl/json_token_lexer.sv]
// Top level of the streaming JSON token lexer.
//
//   Channel  Direction  Handshake             Payload
//   input    in         in_valid / in_stall   text_byte, end_of_text
//   output   out        out_valid / out_stall token_kind .. last_of_run
//
// A byte is classified in the cycle it is taken; its events (up to three) are
// queued as one bundle and pass one by one into the back end's output register.
// While out_stall is low the back end issues one event per cycle, so the events
// of a byte leave one after another; a four-bundle queue absorbs such bursts,
// and one byte per cycle is then sustained while bytes average at most one each.
// in_stall rises only when the queue is full; a stalled output holds its event.
// Reset empties the queue and returns the lexer to line 1, column 0.
`default_nettype none

module json_token_lexer #(
    parameter int POSITION_BITS = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  text_byte,
    input  wire logic        end_of_text,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [3:0]       token_kind,
    output logic             begins,
    output logic             ends,
    output logic             has_byte,
    output logic [7:0]       value_byte,
    output logic             bool_true,
    output logic [15:0]      line_number,
    output logic [15:0]      column_number,
    output logic             error_flag,
    output logic             last_of_run
);
    import jtl_pkg::*;

    event_bundle_t bundle;
    event_bundle_t head;
    token_event_t  out_event;
    logic          accept;
    logic          push;
    logic          pop;
    logic          full;
    logic          head_valid;

    assign in_stall = full;
    assign accept   = in_valid && !full;
    assign push     = accept && (bundle.count != 2'd0);

    jtl_front #(
        .POSITION_BITS(POSITION_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .text_byte  (text_byte),
        .end_of_text(end_of_text),
        .accept     (accept),
        .bundle     (bundle)
    );

    jtl_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (bundle),
        .pop       (pop),
        .full      (full),
        .head_valid(head_valid),
        .head      (head)
    );

    jtl_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_valid(head_valid),
        .head      (head),
        .pop       (pop),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_event (out_event),
        .out_last  (last_of_run)
    );

    assign token_kind    = out_event.kind;
    assign begins        = out_event.begins;
    assign ends          = out_event.ends;
    assign has_byte      = out_event.has_byte;
    assign value_byte    = out_event.value_byte;
    assign bool_true     = out_event.bool_true;
    assign line_number   = out_event.line_number;
    assign column_number = out_event.column_number;
    assign error_flag    = out_event.error_flag;

endmodule

`default_nettype wire

[hdl/jtl_checker.sv]
// Port-level checks on the lexer's output events, bound to the top level.
`default_nettype none

module jtl_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [3:0]  token_kind,
    input wire logic        begins,
    input wire logic        ends,
    input wire logic        has_byte,
    input wire logic [7:0]  value_byte,
    input wire logic        bool_true,
    input wire logic        error_flag,
    input wire logic        last_of_run
);
    import jtl_pkg::*;

    // A stalled event must be offered again unchanged.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(token_kind) && $stable(value_byte)
            && $stable(last_of_run))
        else $error("stalled output event changed");

    // An unterminated string report always closes the string and ends the byte's run.
    a_error: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && error_flag |-> ends && last_of_run && token_kind == K_STRING)
        else $error("error event is not a closing string event");

    // Without a value byte the byte field reads as zero.
    a_nobyte: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !has_byte |-> value_byte == 8'd0)
        else $error("value byte set without has_byte");

    // Only bool tokens may carry the true flag.
    a_bool: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && bool_true |-> token_kind == K_BOOL && begins && ends)
        else $error("true flag on a non-bool event");

    // Value bytes belong only to strings and numbers.
    a_value_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && has_byte |-> token_kind == K_STRING || token_kind == K_NUMBER)
        else $error("value byte on a punctuation or literal event");

endmodule

bind json_token_lexer jtl_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .token_kind (token_kind),
    .begins     (begins),
    .ends       (ends),
    .has_byte   (has_byte),
    .value_byte (value_byte),
    .bool_true  (bool_true),
    .error_flag (error_flag),
    .last_of_run(last_of_run)
);

`default_nettype wire

[tb/tb_json_token_lexer.sv]
// Self-checking testbench for the streaming JSON token lexer.
`timescale 1ns / 1ps

module tb_json_token_lexer;

    import jtl_pkg::*;

    localparam int          LIMIT_CYCLES = 1000000;
    localparam int          DRAIN_CYCLES = 20;
    localparam int          HOLD_CYCLES  = 60;
    localparam int          PHASE_BYTES  = 130;
    localparam logic [15:0] POS_MAX      = 16'hFFFF;
    localparam logic [7:0]  CH_SPACE     = 8'h20;
    localparam logic [7:0]  CH_TAB       = 8'h09;
    localparam logic [7:0]  CH_RETURN    = 8'h0D;

    typedef struct packed {
        logic [7:0]   chr;
        logic         eot;
        logic         typed;
        token_event_t want;
    } stim_t;

    typedef struct packed {
        token_event_t ev;
        logic         last;
    } lex_event_t;

    localparam token_event_t NO_WANT = '0;

    localparam logic [7:0] PUNCT [6] = '{CH_LBRACE, CH_RBRACE, CH_LBRACKET,
                                         CH_RBRACKET, CH_COLON, CH_COMMA};

    // Rows with a typed event carry the single result that the byte gives.
    localparam stim_t DIRECTED [28] = '{
        '{CH_LBRACE,   1'b0, 1'b1, '{K_LBRACE, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0,
                                     16'd1, 16'd1, 1'b0}},
        '{CH_QUOTE,    1'b0, 1'b0, NO_WANT},
        '{8'h61,       1'b0, 1'b0, NO_WANT},
        '{CH_BSLASH,   1'b0, 1'b0, NO_WANT},
        '{CH_QUOTE,    1'b0, 1'b0, NO_WANT},
        '{CH_BSLASH,   1'b0, 1'b0, NO_WANT},
        '{8'h78,       1'b0, 1'b0, NO_WANT},
        '{CH_QUOTE,    1'b0, 1'b0, NO_WANT},
        '{CH_COLON,    1'b0, 1'b1, '{K_COLON, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0,
                                     16'd1, 16'd9, 1'b0}},
        '{CH_MINUS,    1'b0, 1'b0, NO_WANT},
        '{CH_NINE,     1'b0, 1'b0, NO_WANT},
        '{CH_DOT,      1'b0, 1'b0, NO_WANT},
        '{CH_COMMA,    1'b0, 1'b0, NO_WANT},
        '{CH_N,        1'b0, 1'b1, '{K_NULL, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0,
                                     16'd1, 16'd14, 1'b0}},
        '{8'hFF,       1'b0, 1'b0, NO_WANT},
        '{8'h00,       1'b0, 1'b0, NO_WANT},
        '{CH_NEWLINE,  1'b0, 1'b0, NO_WANT},
        '{CH_T,        1'b0, 1'b1, '{K_BOOL, 1'b1, 1'b1, 1'b0, 8'h00, 1'b1,
                                     16'd2, 16'd1, 1'b0}},
        '{8'h80,       1'b0, 1'b0, NO_WANT},
        '{8'h7F,       1'b0, 1'b0, NO_WANT},
        '{CH_QUOTE,    1'b0, 1'b0, NO_WANT},
        '{CH_F,        1'b0, 1'b1, '{K_BOOL, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0,
                                     16'd2, 16'd5, 1'b0}},
        '{CH_LBRACKET, 1'b1, 1'b0, NO_WANT},
        '{CH_QUOTE,    1'b0, 1'b1, '{K_STRING, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0,
                                     16'd1, 16'd1, 1'b0}},
        '{CH_BSLASH,   1'b0, 1'b0, NO_WANT},
        '{8'h41,       1'b1, 1'b0, NO_WANT},
        '{CH_RBRACKET, 1'b0, 1'b1, '{K_RBRACKET, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0,
                                     16'd1, 16'd1, 1'b0}},
        '{CH_NINE,     1'b1, 1'b0, NO_WANT}
    };

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        in_valid    = 1'b0;
    logic        in_stall;
    logic [7:0]  text_byte   = 8'h00;
    logic        end_of_text = 1'b0;
    logic        out_valid;
    logic        out_stall   = 1'b0;
    logic [3:0]  token_kind;
    logic        begins;
    logic        ends;
    logic        has_byte;
    logic [7:0]  value_byte;
    logic        bool_true;
    logic [15:0] line_number;
    logic [15:0] column_number;
    logic        error_flag;
    logic        last_of_run;

    // Lexer state as the predictor sees it.
    lex_mode_t   mode;
    logic [2:0]  skip_left;
    logic        bs_pending;
    logic [15:0] cur_line;
    logic [15:0] cur_col;
    logic [15:0] tok_line;
    logic [15:0] tok_col;

    stim_t        byte_queue [$];
    stim_t        offered;
    token_event_t byte_events [$];
    lex_event_t   expected_events [$];
    lex_event_t   want;
    token_event_t seen;

    int   send_idle_pct = 38;
    int   recv_idle_pct = 52;
    int   queued_bytes  = 0;
    int   fail_count    = 0;
    int   cycle_count   = 0;
    int   hold_left     = 0;
    logic squeeze_req   = 1'b0;
    logic squeeze_done  = 1'b0;

    always #2 clk = ~clk;

    json_token_lexer #(
        .POSITION_BITS(16)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .text_byte    (text_byte),
        .end_of_text  (end_of_text),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .token_kind   (token_kind),
        .begins       (begins),
        .ends         (ends),
        .has_byte     (has_byte),
        .value_byte   (value_byte),
        .bool_true    (bool_true),
        .line_number  (line_number),
        .column_number(column_number),
        .error_flag   (error_flag),
        .last_of_run  (last_of_run)
    );

    function automatic void clear_lexer();
        mode       = MODE_IDLE;
        skip_left  = 3'd0;
        bs_pending = 1'b0;
        cur_line   = 16'd1;
        cur_col    = 16'd0;
        tok_line   = 16'd1;
        tok_col    = 16'd0;
    endfunction

    function automatic void push_token(logic [3:0] kind, logic b, logic e, logic has,
                                       logic [7:0] val, logic bt, logic [15:0] ln,
                                       logic [15:0] col, logic err);
        token_event_t t;
        t = '{kind, b, e, has, has ? val : 8'h00, bt, ln, col, err};
        byte_events.push_back(t);
    endfunction

    function automatic logic is_digit(logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    // Works out the token events that one text byte gives and moves the state on.
    function automatic void predict_events(logic [7:0] c, logic eot);
        logic       fresh;
        logic       punct;
        logic [3:0] pk;
        fresh = 1'b0;
        punct = 1'b1;
        pk    = K_LBRACE;
        byte_events.delete();
        if (cur_col != POS_MAX)
            cur_col++;
        case (mode)
            MODE_STRING:
            begin
                // A pending backslash gives a quote if a quote follows, else itself.
                if (bs_pending)
                    push_token(K_STRING, 1'b0, 1'b0, 1'b1,
                               (c == CH_QUOTE) ? CH_QUOTE : CH_BSLASH,
                               1'b0, tok_line, tok_col, 1'b0);
                if (c == CH_QUOTE && !bs_pending)
                begin
                    push_token(K_STRING, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0,
                               tok_line, tok_col, 1'b0);
                    mode = MODE_IDLE;
                end
                else if (c != CH_QUOTE && c != CH_BSLASH)
                    push_token(K_STRING, 1'b0, 1'b0, 1'b1, c, 1'b0,
                               tok_line, tok_col, 1'b0);
                bs_pending = (c == CH_BSLASH);
            end
            MODE_NUMBER:
            begin
                if (is_digit(c) || c == CH_DOT)
                    push_token(K_NUMBER, 1'b0, 1'b0, 1'b1, c, 1'b0,
                               tok_line, tok_col, 1'b0);
                else
                begin
                    push_token(K_NUMBER, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0,
                               tok_line, tok_col, 1'b0);
                    mode  = MODE_IDLE;
                    fresh = 1'b1;
                end
            end
            MODE_LITERAL:
            begin
                if (skip_left != 3'd0)
                    skip_left--;
                if (skip_left == 3'd0)
                    mode = MODE_IDLE;
            end
            default:
                fresh = 1'b1;
        endcase

        if (fresh)
        begin
            case (c)
                CH_LBRACE:   pk = K_LBRACE;
                CH_RBRACE:   pk = K_RBRACE;
                CH_LBRACKET: pk = K_LBRACKET;
                CH_RBRACKET: pk = K_RBRACKET;
                CH_COLON:    pk = K_COLON;
                CH_COMMA:    pk = K_COMMA;
                default:     punct = 1'b0;
            endcase
            if (punct)
                push_token(pk, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0, cur_line, cur_col, 1'b0);
            else if (c == CH_QUOTE)
            begin
                tok_line   = cur_line;
                tok_col    = cur_col;
                mode       = MODE_STRING;
                bs_pending = 1'b0;
                push_token(K_STRING, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0,
                           cur_line, cur_col, 1'b0);
            end
            else if (is_digit(c) || c == CH_MINUS)
            begin
                tok_line = cur_line;
                tok_col  = cur_col;
                mode     = MODE_NUMBER;
                push_token(K_NUMBER, 1'b1, 1'b0, 1'b1, c, 1'b0, cur_line, cur_col, 1'b0);
            end
            else if (c == CH_N || c == CH_T || c == CH_F)
            begin
                push_token((c == CH_N) ? K_NULL : K_BOOL, 1'b1, 1'b1, 1'b0, 8'h00,
                           c == CH_T, cur_line, cur_col, 1'b0);
                mode      = MODE_LITERAL;
                skip_left = (c == CH_F) ? SKIP_LONG : SKIP_SHORT;
            end
        end

        // Newlines count everywhere, inside strings and skipped literals too.
        if (c == CH_NEWLINE)
        begin
            if (cur_line != POS_MAX)
                cur_line++;
            cur_col = 16'd0;
        end

        if (eot)
        begin
            if (mode == MODE_STRING)
            begin
                if (bs_pending)
                    push_token(K_STRING, 1'b0, 1'b0, 1'b1, CH_BSLASH, 1'b0,
                               tok_line, tok_col, 1'b0);
                push_token(K_STRING, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0,
                           tok_line, tok_col, 1'b1);
            end
            else if (mode == MODE_NUMBER)
                push_token(K_NUMBER, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0,
                           tok_line, tok_col, 1'b0);
            clear_lexer();
        end
    endfunction

    function automatic void queue_byte(logic [7:0] c, logic eot);
        stim_t s;
        s = '{c, eot, 1'b0, NO_WANT};
        byte_queue.push_back(s);
        queued_bytes++;
    endfunction

    function automatic logic eot_roll();
        return $urandom_range(0, 99) < 3;
    endfunction

    // Appends one token-shaped fragment with random content, or a little noise.
    function automatic void queue_fragment();
        int         pick;
        int         len;
        int         r;
        logic [7:0] ch;
        string      lit;
        pick = $urandom_range(0, 99);
        if (pick < 25)
            queue_byte(PUNCT[$urandom_range(0, 5)], eot_roll());
        else if (pick < 45)
        begin
            queue_byte(CH_QUOTE, eot_roll());
            len = $urandom_range(0, 8);
            for (int i = 0; i < len; i++)
            begin
                r = $urandom_range(0, 9);
                if (r < 6)
                begin
                    ch = 8'($urandom_range(32, 126));
                    if (ch == CH_QUOTE || ch == CH_BSLASH)
                        ch = 8'h5F;
                end
                else if (r == 6)
                begin
                    queue_byte(CH_BSLASH, eot_roll());
                    ch = $urandom_range(0, 1) ? CH_QUOTE : 8'($urandom_range(32, 126));
                end
                else if (r == 7)
                    ch = CH_NEWLINE;
                else
                    ch = 8'($urandom_range(0, 255));
                queue_byte(ch, eot_roll());
            end
            queue_byte(CH_QUOTE, eot_roll());
        end
        else if (pick < 65)
        begin
            queue_byte(($urandom_range(0, 3) == 0) ? CH_MINUS
                                                   : CH_ZERO + 8'($urandom_range(0, 9)),
                       eot_roll());
            len = $urandom_range(0, 6);
            for (int i = 0; i < len; i++)
                queue_byte(($urandom_range(0, 4) == 0) ? CH_DOT
                                                       : CH_ZERO + 8'($urandom_range(0, 9)),
                           eot_roll());
        end
        else if (pick < 80)
        begin
            r = $urandom_range(0, 2);
            lit = (r == 0) ? "null" : (r == 1) ? "true" : "false";
            for (int i = 0; i < lit.len(); i++)
                queue_byte(lit[i], eot_roll());
        end
        else if (pick < 90)
        begin
            r = $urandom_range(0, 3);
            queue_byte((r == 0) ? CH_SPACE : (r == 1) ? CH_TAB :
                       (r == 2) ? CH_NEWLINE : CH_RETURN, eot_roll());
        end
        else
        begin
            len = $urandom_range(1, 3);
            for (int i = 0; i < len; i++)
                queue_byte(8'($urandom_range(0, 255)), eot_roll());
        end
    endfunction

    function automatic void fill_random(int count);
        int start;
        start = queued_bytes;
        while (queued_bytes - start < count)
            queue_fragment();
    endfunction

    function automatic string show(token_event_t t, logic last);
        return $sformatf({"kind %0d beg %0b end %0b has %0b val %02h bool %0b ",
                          "line %0d col %0d err %0b last %0b"},
                         t.kind, t.begins, t.ends, t.has_byte, t.value_byte,
                         t.bool_true, t.line_number, t.column_number,
                         t.error_flag, last);
    endfunction

    // Sender: a payload is held until its transfer; the next one follows at once
    // or after a random gap.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                predict_events(text_byte, end_of_text);
                if (offered.typed)
                begin
                    byte_events.delete();
                    byte_events.push_back(offered.want);
                end
                foreach (byte_events[k])
                    expected_events.push_back(
                        lex_event_t'{byte_events[k], k == byte_events.size() - 1});
            end
            if (!in_valid || !in_stall)
            begin
                if (byte_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    offered = byte_queue.pop_front();
                    in_valid    <= 1'b1;
                    text_byte   <= offered.chr;
                    end_of_text <= offered.eot;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Receiver: checks every transfer against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                seen = '{token_kind, begins, ends, has_byte, value_byte, bool_true,
                         line_number, column_number, error_flag};
                if (expected_events.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("Unexpected token event: %s", show(seen, last_of_run));
                    fail_count++;
                end
                else
                begin
                    want = expected_events.pop_front();
                    if (want.ev !== seen || want.last !== last_of_run)
                    begin
                        if (fail_count < 10)
                        begin
                            $display("Mismatch expected: %s", show(want.ev, want.last));
                            $display("         actual:   %s", show(seen, last_of_run));
                        end
                        fail_count++;
                    end
                end
            end
            if (squeeze_req && !squeeze_done)
            begin
                hold_left    = HOLD_CYCLES;
                squeeze_done = 1'b1;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == LIMIT_CYCLES)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        clear_lexer();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        foreach (DIRECTED[i])
            byte_queue.push_back(DIRECTED[i]);
        fill_random(PHASE_BYTES);
        while (byte_queue.size() != 0)
            @(posedge clk);

        send_idle_pct = 52;
        recv_idle_pct = 38;
        fill_random(PHASE_BYTES);
        while (byte_queue.size() != 0)
            @(posedge clk);

        // No idling from here; the receiver first holds off long enough for the
        // block to fill up and stall its input.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        squeeze_req   = 1'b1;
        fill_random(PHASE_BYTES);

        while (byte_queue.size() != 0 || in_valid || expected_events.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

[json_token_lexer.f]
hdl/jtl_pkg.sv
hdl/jtl_front.sv
hdl/jtl_queue.sv
hdl/jtl_back.sv
hdl/json_token_lexer.sv
hdl/jtl_checker.sv
tb/tb_json_token_lexer.sv
